// File: sv/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg: shared types and constants of the periodic event timer bank
// Operation codes, queue entry, sequencer states, divider handshake.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int MAX_FIRINGS = 64;
  localparam int TIDX_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W       = $clog2(MAX_FIRINGS + 1);
  localparam int DVD_W       = 34;
  localparam int DVS_W       = 24;
  localparam int PERMILLE    = 1000;
  localparam logic [31:0] PEND_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ADD    = 3'd1,
    OP_RESET  = 3'd2,
    OP_DELETE = 3'd3,
    OP_QUERY  = 3'd4
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  idx;
    logic        inb;
    logic [23:0] per;
    logic        rep;
    logic [15:0] clk;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHARGE, S_SWEEP, S_CATCH, S_CWAIT, S_MIN, S_FLUSH,
    S_QMUL, S_QSTART, S_QDIV, S_QOUT
  } back_state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] remdr;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [TIDX_W-1:0] tidx(input logic [3:0] idx);
    logic [TIDX_W+3:0] e;
    e = {{TIDX_W{1'b0}}, idx};
    return e[TIDX_W-1:0];
  endfunction

endpackage

// File: sv/pet_front.sv
// ----------------------------------------------------------------------------
// pet_front: input acceptance and classification
// Decode the operation, drop items without effect, queue the rest.
// ----------------------------------------------------------------------------
module pet_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [47:0]   s_tdata,
  input  logic [2:0]    s_tuser,
  output logic          head_valid,
  output pet_pkg::cmd_t head,
  input  logic          pop
);
  import pet_pkg::*;

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;
  cmd_t       cmd;
  logic       keep;
  logic       push;

  always_comb begin
    cmd.op  = op_e'(s_tuser);
    cmd.idx = s_tdata[3:0];
    cmd.inb = 32'(s_tdata[3:0]) < 32'(NUM_TIMERS);
    cmd.per = s_tdata[27:4];
    cmd.rep = s_tdata[28];
    cmd.clk = s_tdata[44:29];
    case (s_tuser)
      OP_TICK, OP_QUERY:           keep = 1'b1;
      OP_ADD, OP_RESET, OP_DELETE: keep = cmd.inb;
      default:                     keep = 1'b0;
    endcase
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready && keep;
  assign head_valid = (count != 2'd0);
  assign head       = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= cmd;
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/pet_div.sv
// ----------------------------------------------------------------------------
// pet_div: serial restoring divider
// One quotient bit a cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module pet_div (
  input  logic              clk,
  input  logic              rst,
  input  pet_pkg::div_req_t req,
  output pet_pkg::div_rsp_t rsp
);
  import pet_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] r;
  logic [DVS_W-1:0] d;
  logic [DVD_W-1:0] dq;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   t;
  logic             ge;

  always_comb begin
    t  = {r, dq[DVD_W-1]};
    ge = t >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      r  <= '0;
      d  <= req.divisor;
      dq <= req.dividend;
    end else if (busy) begin
      r  <= ge ? DVS_W'(t - {1'b0, d}) : t[DVS_W-1:0];
      dq <= {dq[DVD_W-2:0], ge};
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.quot  = dq;
  assign rsp.remdr = r;

endmodule

// File: sv/pet_back.sv
// ----------------------------------------------------------------------------
// pet_back: timer state and operation sequencer
// Carry out queued operations, run tick passes, drive the result register.
// ----------------------------------------------------------------------------
module pet_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  pet_pkg::cmd_t     head,
  output logic              pop,
  output pet_pkg::div_req_t dreq,
  input  pet_pkg::div_rsp_t drsp,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);
  import pet_pkg::*;

  back_state_e state, state_next;

  logic               act [NUM_TIMERS];
  logic signed [31:0] rem [NUM_TIMERS];
  logic [23:0]        rel [NUM_TIMERS];
  logic [31:0]        pending;
  logic signed [31:0] earliest;

  logic [TIDX_W-1:0]  i;
  logic [CNT_W-1:0]   n;
  logic               ov, again, hv;
  logic [3:0]         h_idx;
  logic               o_valid, o_fired, o_act, o_ov, o_last;
  logic [3:0]         o_idx;
  logic [9:0]         o_prog;
  logic signed [33:0] num;
  logic [33:0]        prod;
  logic [23:0]        qp;
  logic               q_act;
  logic [9:0]         q_prog;
  logic [3:0]         q_idx;

  logic [TIDX_W-1:0]  addr;
  logic               ra;
  logic signed [31:0] rr;
  logic [23:0]        rl;
  logic               free, due, below, stall, last_i, again_now, catch_hit, pass;
  logic signed [31:0] rem_plus, rem_minus, rem_reset;
  logic [32:0]        pend_sum;
  logic [31:0]        pend_new;
  logic [CNT_W-1:0]   n_next;

  always_comb begin
    addr      = (state == S_IDLE) ? tidx(head.idx) : i;
    ra        = act[addr];
    rr        = rem[addr];
    rl        = rel[addr];
    free      = !o_valid || m_tready;
    last_i    = (i == TIDX_W'(NUM_TIMERS - 1));
    due       = ra && (rr <= 0);
    below     = n < CNT_W'(MAX_FIRINGS);
    stall     = due && below && hv && !free;
    rem_plus  = sat32(34'(rr) + $signed({10'b0, rl}));
    rem_minus = sat32(34'(rr) - $signed({2'b0, pending}));
    rem_reset = sat32($signed({10'b0, rl}) + $signed({2'b0, pending}));
    again_now = again || (due && (rl != 24'd0) && (rem_plus <= 0));
    n_next    = n + CNT_W'(due && below);
    catch_hit = ra && (rr <= 0) && (rl != 24'd0);
    pend_sum  = {1'b0, pending} + 33'(head.clk);
    pend_new  = (pend_sum > 33'(PEND_MAX)) ? PEND_MAX : pend_sum[31:0];
    pass      = (head.clk == 16'd0) ||
                !($signed({earliest[31], earliest}) > $signed({1'b0, pend_new}));

    pop        = 1'b0;
    dreq.start = 1'b0;
    dreq.dividend = prod;
    dreq.divisor  = qp;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.op)
            OP_TICK:  if (pass) state_next = S_CHARGE;
            OP_QUERY: state_next = (head.inb && ra && rl != 24'd0) ? S_QMUL : S_QOUT;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_CHARGE: if (last_i) state_next = S_SWEEP;
      S_SWEEP: begin
        if (!stall && last_i) begin
          if (again_now && n_next >= CNT_W'(MAX_FIRINGS)) state_next = S_CATCH;
          else if (again_now)                            state_next = S_SWEEP;
          else                                           state_next = S_MIN;
        end
      end
      S_CATCH: begin
        if (catch_hit) begin
          dreq.start    = 1'b1;
          dreq.dividend = DVD_W'(-34'(rr));
          dreq.divisor  = rl;
          state_next    = S_CWAIT;
        end else if (last_i) begin
          state_next = S_MIN;
        end
      end
      S_CWAIT: if (drsp.done) state_next = last_i ? S_MIN : S_CATCH;
      S_MIN:   if (last_i) state_next = S_FLUSH;
      S_FLUSH: if (!hv || free) state_next = S_IDLE;
      S_QMUL: begin
        if (num <= 0 || num >= $signed({10'b0, qp})) state_next = S_QOUT;
        else                                          state_next = S_QSTART;
      end
      S_QSTART: begin
        dreq.start = 1'b1;
        state_next = S_QDIV;
      end
      S_QDIV: if (drsp.done) state_next = S_QOUT;
      S_QOUT: if (free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        act[k] <= 1'b0;
        rem[k] <= '0;
        rel[k] <= '0;
      end
      pending  <= '0;
      earliest <= '0;
      o_valid  <= 1'b0;
      hv       <= 1'b0;
      i        <= '0;
      n        <= '0;
      ov       <= 1'b0;
      again    <= 1'b0;
    end else begin
      if (o_valid && m_tready) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          i     <= '0;
          n     <= '0;
          ov    <= 1'b0;
          again <= 1'b0;
          if (head_valid) begin
            case (head.op)
              OP_TICK: pending <= pend_new;
              OP_ADD: begin
                act[addr] <= 1'b1;
                rem[addr] <= $signed({8'b0, head.per});
                rel[addr] <= head.rep ? ((head.per == 24'd0) ? 24'd1 : head.per) : 24'd0;
                if (earliest < 0 || $signed({8'b0, head.per}) < earliest)
                  earliest <= $signed({8'b0, head.per});
              end
              OP_RESET:  if (ra) rem[addr] <= rem_reset;
              OP_DELETE: act[addr] <= 1'b0;
              OP_QUERY: begin
                q_idx  <= head.idx;
                q_act  <= head.inb && ra;
                q_prog <= '0;
                qp     <= rl;
                num    <= $signed({10'b0, rl}) - 34'(rr) + $signed({2'b0, pending});
              end
              default: ;
            endcase
          end
        end
        S_CHARGE: begin
          if (ra) rem[i] <= rem_minus;
          i <= i + TIDX_W'(1);
          if (last_i) begin
            pending <= '0;
            i       <= '0;
          end
        end
        S_SWEEP: begin
          if (!stall) begin
            if (due) begin
              if (below) begin
                if (hv) begin
                  // push the held firing; it is not the final one
                  o_valid <= 1'b1;
                  o_fired <= 1'b1;
                  o_idx   <= h_idx;
                  o_act   <= 1'b0;
                  o_prog  <= '0;
                  o_ov    <= 1'b0;
                  o_last  <= 1'b0;
                end
                hv    <= 1'b1;
                h_idx <= 4'(i);
              end else begin
                ov <= 1'b1;
              end
              if (rl != 24'd0) rem[i] <= rem_plus;
              else             act[i] <= 1'b0;
            end
            n     <= n_next;
            again <= again_now;
            i     <= i + TIDX_W'(1);
            if (last_i) begin
              i     <= '0;
              again <= 1'b0;
              if (!again_now || n_next < CNT_W'(MAX_FIRINGS)) begin
                if (!again_now) earliest <= -32'sd1;
              end
            end
          end
        end
        S_CATCH: begin
          if (!catch_hit) begin
            i <= i + TIDX_W'(1);
            if (last_i) begin
              i        <= '0;
              earliest <= -32'sd1;
            end
          end
        end
        S_CWAIT: begin
          if (drsp.done) begin
            rem[i] <= $signed({8'b0, rl - drsp.remdr});
            ov     <= 1'b1;
            i      <= i + TIDX_W'(1);
            if (last_i) begin
              i        <= '0;
              earliest <= -32'sd1;
            end
          end
        end
        S_MIN: begin
          if (ra && (earliest < 0 || rr < earliest)) earliest <= rr;
          i <= i + TIDX_W'(1);
        end
        S_FLUSH: begin
          if (hv && free) begin
            o_valid <= 1'b1;
            o_fired <= 1'b1;
            o_idx   <= h_idx;
            o_act   <= 1'b0;
            o_prog  <= '0;
            o_ov    <= ov;
            o_last  <= 1'b1;
            hv      <= 1'b0;
          end
        end
        S_QMUL: begin
          prod <= {10'b0, num[23:0]} * 34'(PERMILLE);
          if (num >= $signed({10'b0, qp}) && num > 0) q_prog <= 10'(PERMILLE);
        end
        S_QDIV: if (drsp.done) q_prog <= drsp.quot[9:0];
        S_QOUT: begin
          if (free) begin
            o_valid <= 1'b1;
            o_fired <= 1'b0;
            o_idx   <= q_idx;
            o_act   <= q_act;
            o_prog  <= q_prog;
            o_ov    <= 1'b0;
            o_last  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_ov, o_prog, o_act, o_idx};
  assign m_tlast  = o_last;
  assign m_tuser  = o_fired;

endmodule

// File: sv/periodic_event_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_event_timer_bank: bank of one-shot and repeating countdown timers
// Stream in operations, stream out expiry reports and query answers.
// ----------------------------------------------------------------------------
// Sixteen timers driven by a stream of operations (tick, add, reset, delete,
// query). Add, reset and delete are handled in the sequencer's idle state
// and give no beat. A query gives one beat; when the timer is active and
// repeats, its per-mille progress goes through the serial divider unless it
// is 0 or 1000. A tick that reaches the earliest deadline (or carries zero
// clocks) runs a pass: charge the pending count into every active timer,
// sweep once per round of firings, run a catch-up reload through the divider
// for each repeating timer still due once the 64-beat limit is reached, and
// find the new earliest deadline. A two-entry queue in front lets items
// arrive while a pass runs, and the output register holds a beat while the
// next one is prepared. Each firing up to the 64-beat limit gives one beat;
// the final beat of a pass carries tlast and the overrun flag.
module periodic_event_timer_bank (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // event_index[3:0], period_clocks[27:4],
                                 // repeat_mode[28], elapsed_clocks[44:29]
  input  logic [2:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // fired_index[3:0], active[4],
                                 // progress[14:5], overrun[15]
  output logic        m_tlast,   // last
  output logic        m_tuser    // fired
);
  import pet_pkg::*;

  logic     head_valid;
  cmd_t     head;
  logic     pop;
  div_req_t dreq;
  div_rsp_t drsp;

  // accept and classify operations
  pet_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .head_valid, .head, .pop
  );

  // shared divider for catch-up reloads and progress
  pet_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  // advance timers and deliver result beats
  pet_back u_back (
    .clk, .rst, .head_valid, .head, .pop, .dreq, .drsp,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
  );

  a_query_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && !m_tdata[15])
    else $error("query beat without last or with overrun");

  a_fired_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[14:4] == 11'd0)
    else $error("expiry beat carries query fields");

  a_prog_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[14:5] <= 10'd1000)
    else $error("progress above 1000");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the periodic event timer bank
// Streams directed and random operations, predicts every expiry report and
// query answer in a behavioural copy of the bank, and checks each beat.
// ----------------------------------------------------------------------------
module tb_top;
  import pet_pkg::*;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [23:0] per;
    logic        rep;
    logic [15:0] elapsed;
  } op_item_t;

  typedef struct packed {
    logic       fired;
    logic [3:0] index;
    logic       active;
    logic [9:0] progress;
    logic       overrun;
    logic       last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  periodic_event_timer_bank dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  // Behavioural copy of the bank
  logic               t_on   [NUM_TIMERS];
  logic signed [31:0] t_left [NUM_TIMERS];
  logic        [23:0] t_reld [NUM_TIMERS];
  logic        [31:0] pend;
  logic signed [31:0] soonest;

  op_item_t op_pending[$];
  report_t  reports_due[$];
  int       mismatches = 0;
  bit       stim_done = 1'b0;
  int       hold_off = 0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic report_t expiry(input int i);
    report_t r;
    r = '0;
    r.fired = 1'b1;
    r.index = i[3:0];
    return r;
  endfunction

  // Charge every running timer, fire the due ones pass by pass, rebuild minimum
  task automatic run_timer_pass();
    int n;
    bit ov, again;
    longint p, r, k;
    report_t rr;
    n = 0; ov = 0;
    for (int i = 0; i < NUM_TIMERS; i++)
      if (t_on[i]) t_left[i] = clamp32(longint'(t_left[i]) - longint'(pend));
    pend = 0;
    do begin
      again = 0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (!t_on[i] || t_left[i] > 0) continue;
        if (n < MAX_FIRINGS) begin
          reports_due.push_back(expiry(i));
          n++;
        end else ov = 1;
        if (t_reld[i] > 0) begin
          t_left[i] = clamp32(longint'(t_left[i]) + longint'(t_reld[i]));
          if (t_left[i] <= 0) again = 1;
        end else t_on[i] = 1'b0;
      end
      if (again && n >= MAX_FIRINGS) begin
        for (int i = 0; i < NUM_TIMERS; i++)
          if (t_on[i] && t_left[i] <= 0 && t_reld[i] > 0) begin
            p = t_reld[i]; r = t_left[i];
            k = (-r) / p + 1;
            t_left[i] = clamp32(r + k * p);
            ov = 1;
          end
        again = 0;
      end
    end while (again);
    soonest = -1;
    for (int i = 0; i < NUM_TIMERS; i++)
      if (t_on[i] && (soonest < 0 || t_left[i] < soonest)) soonest = t_left[i];
    if (n > 0) begin
      rr = reports_due.pop_back();
      rr.last = 1'b1;
      rr.overrun = ov;
      reports_due.push_back(rr);
    end
  endtask

  task automatic predict_op(input op_item_t it);
    longint s, p, num;
    report_t rr;
    case (it.op)
      OP_TICK: begin
        s = longint'(pend) + it.elapsed;
        pend = (s > PEND_MAX) ? PEND_MAX : s[31:0];
        if (!(it.elapsed != 0 && longint'(soonest) > longint'(pend))) run_timer_pass();
      end
      OP_ADD: begin
        t_on[it.idx] = 1'b1;
        t_left[it.idx] = {8'd0, it.per};
        t_reld[it.idx] = it.rep ? ((it.per < 1) ? 24'd1 : it.per) : 24'd0;
        if (soonest < 0 || $signed({8'd0, it.per}) < soonest) soonest = {8'd0, it.per};
      end
      OP_RESET:
        if (t_on[it.idx])
          t_left[it.idx] = clamp32(longint'(t_reld[it.idx]) + longint'(pend));
      OP_DELETE: t_on[it.idx] = 1'b0;
      OP_QUERY: begin
        rr = '0;
        rr.index = it.idx;
        rr.last = 1'b1;
        if (t_on[it.idx]) begin
          rr.active = 1'b1;
          if (t_reld[it.idx] > 0) begin
            p = t_reld[it.idx];
            num = p - longint'(t_left[it.idx]) + longint'(pend);
            if (num <= 0) rr.progress = '0;
            else if (num >= p) rr.progress = 10'(PERMILLE);
            else rr.progress = 10'((num * 1000) / p);
          end
        end
        reports_due.push_back(rr);
      end
      default: ;
    endcase
  endtask

  initial forever #1 clk = ~clk;

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_op(op_pending.pop_front());
      end
      if (!s_tvalid || s_tready) begin
        // Keep valid high across beats of a burst, lower it on gaps or when no operation waits
        if (gap_left > 0 || op_pending.size() <= (s_tvalid && s_tready ? 0 : 0)) begin
          if (gap_left > 0) gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (op_pending.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tuser <= op_pending[0].op;
          s_tdata <= {3'd0, op_pending[0].elapsed, op_pending[0].rep,
                      op_pending[0].per, op_pending[0].idx};
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: own stall pattern, plus a long hold-off while pressure is on
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else m_tready <= ($urandom_range(0, 9) < 7);
  end

  // Monitor: compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    report_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[3:0], m_tdata[4], m_tdata[14:5], m_tdata[15], m_tlast};
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h", got);
      end else begin
        want = reports_due.pop_front();
        if (want !== got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: fired %b/%b idx %0d/%0d act %b/%b prog %0d/%0d ov %b/%b last %b/%b",
                     want.fired, got.fired, want.index, got.index, want.active, got.active,
                     want.progress, got.progress, want.overrun, got.overrun,
                     want.last, got.last);
        end
      end
    end
  end

  function automatic op_item_t mk(input logic [2:0] op, input int idx, input int per,
                                  input bit rep, input int el);
    op_item_t it;
    it.op = op; it.idx = idx[3:0]; it.per = per[23:0]; it.rep = rep; it.elapsed = el[15:0];
    return it;
  endfunction

  function automatic int rand_period();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 24'hFF_FFFF;
      2: return $urandom_range(1, 24'hFF_FFFF);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic op_item_t rand_op();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return mk(OP_ADD, $urandom_range(0, 15), rand_period(), $urandom_range(0, 1), $urandom);
    if (sel < 55) return mk(OP_TICK, $urandom, $urandom,
                            $urandom_range(0, 1),
                            ($urandom_range(0, 7) == 0) ? 0 :
                            ($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom_range(1, 300));
    if (sel < 65) return mk(OP_RESET, $urandom_range(0, 15), $urandom, $urandom_range(0, 1), $urandom);
    if (sel < 72) return mk(OP_DELETE, $urandom_range(0, 15), $urandom, $urandom_range(0, 1), $urandom);
    if (sel < 97) return mk(OP_QUERY, $urandom_range(0, 15), $urandom, $urandom_range(0, 1), $urandom);
    return mk(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom_range(0, 1), $urandom);
  endfunction

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      t_on[i] = 0; t_left[i] = 0; t_reld[i] = 0;
    end
    pend = 0; soonest = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: inactive query, extremes, one-shot, repeat, zero tick, flood
    op_pending.push_back(mk(OP_QUERY, 3, 0, 0, 0));
    op_pending.push_back(mk(OP_ADD, 0, 0, 1, 0));            // period zero, repeat -> 1
    op_pending.push_back(mk(OP_ADD, 15, 24'hFF_FFFF, 1, 16'hFFFF));
    op_pending.push_back(mk(OP_ADD, 5, 10, 0, 0));           // one-shot
    op_pending.push_back(mk(OP_QUERY, 15, 0, 0, 0));
    op_pending.push_back(mk(OP_TICK, 0, 0, 0, 0));           // zero forces a pass
    op_pending.push_back(mk(OP_TICK, 0, 0, 0, 16'hFFFF));
    op_pending.push_back(mk(OP_QUERY, 5, 0, 0, 0));
    op_pending.push_back(mk(OP_RESET, 15, 0, 0, 0));
    op_pending.push_back(mk(OP_RESET, 7, 0, 0, 0));          // inactive, untouched
    op_pending.push_back(mk(OP_QUERY, 15, 0, 0, 0));
    op_pending.push_back(mk(OP_DELETE, 0, 0, 0, 0));
    op_pending.push_back(mk(OP_QUERY, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) op_pending.push_back(mk(OP_ADD, i + 1, 1, 1, 0));
    op_pending.push_back(mk(OP_TICK, 0, 0, 0, 16'hFFFF));   // firing limit and catch-up
    op_pending.push_back(mk(6, 2, 0, 0, 0));                 // unused code
    op_pending.push_back(mk(OP_QUERY, 1, 0, 0, 0));
    op_pending.push_back(mk(OP_ADD, 9, 3, 0, 0));
    op_pending.push_back(mk(OP_TICK, 0, 0, 0, 2));
    op_pending.push_back(mk(OP_TICK, 0, 0, 0, 1));

    // Random: mostly well-formed add/tick/query traffic
    for (int n = 0; n < 430; n++) begin
      op_pending.push_back(rand_op());
      if (n == 200) begin
        wait (op_pending.size() < 60);
        hold_off = 400;                                      // back-pressure stretch
      end
    end
    wait (op_pending.size() == 0 && !s_tvalid);
    stim_done = 1'b1;
    wait (reports_due.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
sv/pet_pkg.sv
sv/pet_front.sv
sv/pet_div.sv
sv/pet_back.sv
sv/periodic_event_timer_bank.sv
tb/tb_top.sv
